@@ rtl/fgps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fgps_pkg;

   // window geometry and pick range
   localparam int WIN_SIZE = 3;
   localparam logic [3:0] PICK_MAX = 4'd8;

   // request and result queue depths
   localparam int QUEUE_DEPTH  = 4;
   localparam int RESULT_DEPTH = 4;

   // configuration registers
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic [11:0] IMAGE_WIDTH_RESET  = 12'd640;
   localparam logic [15:0] IMAGE_HEIGHT_RESET = 16'd480;

   // request and result payloads
   typedef struct packed {
      logic [7:0] chan0;
      logic [7:0] chan1;
      logic [7:0] chan2;
      logic [3:0] pick;
   } req_type;

   typedef struct packed {
      logic [7:0] out_chan0;
      logic [7:0] out_chan1;
      logic [7:0] out_chan2;
      logic       last;
   } rsp_type;

   // one stored pixel
   typedef struct packed {
      logic [7:0] c2;
      logic [7:0] c1;
      logic [7:0] c0;
   } pix_type;

   // one window column, index is the row (0 = two rows up)
   typedef pix_type [WIN_SIZE-1:0] column_type;

   // window position chosen by the pick
   typedef struct packed {
      logic [1:0] prow;
      logic [1:0] pcol;
   } pick_pos_type;

   // classified request passed from front to back
   typedef struct packed {
      pix_type    pix;
      logic [1:0] prow;
      logic [1:0] pcol;
      logic       emit;
      logic       last;
   } work_type;

   // row-major pick to row and column, picks above the window saturate
   function automatic pick_pos_type decode_pick(input logic [3:0] pick);
      pick_pos_type pos;
      case (pick)
         4'd0: pos = '{prow: 2'd0, pcol: 2'd0};
         4'd1: pos = '{prow: 2'd0, pcol: 2'd1};
         4'd2: pos = '{prow: 2'd0, pcol: 2'd2};
         4'd3: pos = '{prow: 2'd1, pcol: 2'd0};
         4'd4: pos = '{prow: 2'd1, pcol: 2'd1};
         4'd5: pos = '{prow: 2'd1, pcol: 2'd2};
         4'd6: pos = '{prow: 2'd2, pcol: 2'd0};
         4'd7: pos = '{prow: 2'd2, pcol: 2'd1};
         default: pos = '{prow: 2'd2, pcol: 2'd2};
      endcase
      return pos;
   endfunction

endpackage

`default_nettype wire

@@ rtl/fgps_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fgps_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   // status
   assign full     = (count_ff == CNTW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/fgps_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fgps_front #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_write,
   input  wire logic [fgps_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [fgps_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata,
   input  wire logic                                    push,
   input  wire fgps_pkg::req_type                       req_data,
   output logic                                         full,
   output logic                                         q_push,
   output fgps_pkg::work_type                           q_work,
   output logic [$clog2(MAX_WIDTH)-1:0]                 q_addr,
   input  wire logic                                    q_full
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = (CW + 1 > 12) ? CW + 1 : 12;

   logic [11:0]        width_ff;
   logic [15:0]        height_ff;
   logic [CW-1:0]      col_ff, col_in;
   logic [15:0]        row_ff, row_in;
   logic [WW-1:0]      width_ext;
   logic [WW-1:0]      eff_width;
   logic [15:0]        eff_height;
   logic [WW-1:0]      col_plus;
   logic [16:0]        row_plus;
   logic               row_end;
   logic               img_end;
   logic               accept;
   fgps_pkg::pick_pos_type pos;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= fgps_pkg::IMAGE_WIDTH_RESET;
         height_ff <= fgps_pkg::IMAGE_HEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            fgps_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[11:0];
            fgps_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // clamp the image size to what the window and line stores support
   assign width_ext = WW'(width_ff);
   always_comb begin
      if (width_ext < WW'(fgps_pkg::WIN_SIZE)) begin
         eff_width = WW'(fgps_pkg::WIN_SIZE);
      end else if (width_ext > WW'(MAX_WIDTH)) begin
         eff_width = WW'(MAX_WIDTH);
      end else begin
         eff_width = width_ext;
      end
      if (height_ff < 16'(fgps_pkg::WIN_SIZE)) begin
         eff_height = 16'(fgps_pkg::WIN_SIZE);
      end else begin
         eff_height = height_ff;
      end
   end

   // row and image end detection
   assign col_plus = WW'(col_ff) + 1'b1;
   assign row_plus = {1'b0, row_ff} + 17'd1;
   assign row_end  = (col_plus >= eff_width);
   assign img_end  = row_end && (row_plus >= {1'b0, eff_height});

   assign accept = push && !q_full;
   assign full   = q_full;

   // raster position counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = img_end ? '0 : row_plus[15:0];
         end else begin
            col_in = CW'(col_plus);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // classify the request for the back end
   assign pos = fgps_pkg::decode_pick(req_data.pick);

   always_comb begin
      q_work.pix.c0 = req_data.chan0;
      q_work.pix.c1 = req_data.chan1;
      q_work.pix.c2 = req_data.chan2;
      q_work.prow   = pos.prow;
      q_work.pcol   = pos.pcol;
      q_work.emit   = (row_ff >= 16'd2) && (col_ff >= CW'(2));
      q_work.last   = img_end;
   end

   assign q_push = accept;
   assign q_addr = col_ff;

   // counter checks
   a_col_step: assert property (@(posedge clock) disable iff (reset)
      (accept && !row_end) |=> (col_ff == CW'($past(col_ff) + 1'b1)))
      else $error("column counter did not advance");

   a_img_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && img_end) |=> ((row_ff == '0) && (col_ff == '0)))
      else $error("counters did not wrap at image end");

endmodule

`default_nettype wire

@@ rtl/fgps_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fgps_back #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_empty,
   input  wire fgps_pkg::work_type            q_work,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]  q_addr,
   output logic                               q_pop,
   input  wire logic                          out_full,
   output logic                               out_push,
   output fgps_pkg::rsp_type                  out_data
);

   localparam int CW = $clog2(MAX_WIDTH);

   // line stores, upper holds two rows up, middle one row up
   fgps_pkg::pix_type    upper_mem_ff  [MAX_WIDTH];
   fgps_pkg::pix_type    middle_mem_ff [MAX_WIDTH];
   fgps_pkg::pix_type    upper_rd_ff;
   fgps_pkg::pix_type    middle_rd_ff;

   logic                 a_valid_ff, a_valid_in;
   fgps_pkg::work_type   a_work_ff;
   logic [CW-1:0]        a_addr_ff;
   logic                 a_fire;

   fgps_pkg::column_type older_col_ff;
   fgps_pkg::column_type newer_col_ff;
   fgps_pkg::column_type cur_col;
   fgps_pkg::column_type sel_col;
   fgps_pkg::pix_type    sel_pix;

   // stage handshakes
   assign a_fire     = a_valid_ff && (!a_work_ff.emit || !out_full);
   assign q_pop      = !q_empty && (!a_valid_ff || a_fire);
   assign a_valid_in = q_pop ? 1'b1 : (a_fire ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_work_ff <= q_work;
         a_addr_ff <= q_addr;
      end
   end

   // line store read on dequeue, write back when the pixel retires
   always_ff @(posedge clock) begin
      if (q_pop) begin
         upper_rd_ff  <= upper_mem_ff[q_addr];
         middle_rd_ff <= middle_mem_ff[q_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (a_fire) begin
         upper_mem_ff[a_addr_ff]  <= middle_rd_ff;
         middle_mem_ff[a_addr_ff] <= a_work_ff.pix;
      end
   end

   // current column of the window
   always_comb begin
      cur_col[0] = upper_rd_ff;
      cur_col[1] = middle_rd_ff;
      cur_col[2] = a_work_ff.pix;
   end

   // window shift
   always_ff @(posedge clock) begin
      if (reset) begin
         older_col_ff <= '0;
         newer_col_ff <= '0;
      end else if (a_fire) begin
         older_col_ff <= newer_col_ff;
         newer_col_ff <= cur_col;
      end
   end

   // neighbor selection
   always_comb begin
      case (a_work_ff.pcol)
         2'd0:    sel_col = older_col_ff;
         2'd1:    sel_col = newer_col_ff;
         default: sel_col = cur_col;
      endcase
      case (a_work_ff.prow)
         2'd0:    sel_pix = sel_col[0];
         2'd1:    sel_pix = sel_col[1];
         default: sel_pix = sel_col[2];
      endcase
   end

   assign out_push = a_fire && a_work_ff.emit;

   always_comb begin
      out_data.out_chan0 = sel_pix.c0;
      out_data.out_chan1 = sel_pix.c1;
      out_data.out_chan2 = sel_pix.c2;
      out_data.last      = a_work_ff.last;
   end

   // pipeline checks
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result pushed into a full queue");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !a_fire) |=> (a_valid_ff && $stable(a_addr_ff)))
      else $error("stalled pixel lost its slot");

endmodule

`default_nettype wire

@@ rtl/frosted_glass_pixel_scatter_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                               moves
// request   push, full, req_data                one pixel and its pick
// result    empty, pop, rsp_data                chosen neighbor pixel, last flag
// csr       csr_write, csr_index, csr_wdata     image width and height
//
// one request per cycle sustained unless a result stall holds the read stage;
// a line store read and write per pixel sets the rate; a result passes the
// request queue, line store read stage and result queue before it can be popped
// reset clears counters, window and queues and loads 640 x 480; line stores
// are not cleared
// full rises when the request queue is full; a stalled result holds the
// read stage, the request queue keeps taking pixels until it fills

module frosted_glass_pixel_scatter_top #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 push,
   input  wire fgps_pkg::req_type                    req_data,
   output logic                                      full,
   output logic                                      empty,
   input  wire logic                                 pop,
   output fgps_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_write,
   input  wire logic [fgps_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [fgps_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int QW    = $bits(fgps_pkg::work_type) + CW;
   localparam int RW    = $bits(fgps_pkg::rsp_type);

   logic               fq_push;
   fgps_pkg::work_type fq_work;
   logic [CW-1:0]      fq_addr;
   logic               fq_full;
   logic [QW-1:0]      bq_data;
   logic               bq_pop;
   logic               bq_empty;
   fgps_pkg::work_type bq_work;
   logic [CW-1:0]      bq_addr;
   logic               res_push;
   logic               res_full;
   fgps_pkg::rsp_type  res_data;
   logic [RW-1:0]      res_out;

   // counters, classification and configuration
   fgps_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .q_push    (fq_push),
      .q_work    (fq_work),
      .q_addr    (fq_addr),
      .q_full    (fq_full)
   );

   // queue between front and back
   fgps_fifo #(
      .WIDTH (QW),
      .DEPTH (fgps_pkg::QUEUE_DEPTH)
   ) u_work_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data ({fq_work, fq_addr}),
      .full      (fq_full),
      .pop       (bq_pop),
      .pop_data  (bq_data),
      .empty     (bq_empty)
   );

   assign bq_work = fgps_pkg::work_type'(bq_data[QW-1:CW]);
   assign bq_addr = bq_data[CW-1:0];

   // line stores, window and neighbor selection
   fgps_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (bq_empty),
      .q_work   (bq_work),
      .q_addr   (bq_addr),
      .q_pop    (bq_pop),
      .out_full (res_full),
      .out_push (res_push),
      .out_data (res_data)
   );

   // result queue
   fgps_fifo #(
      .WIDTH (RW),
      .DEPTH (fgps_pkg::RESULT_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (pop),
      .pop_data  (res_out),
      .empty     (empty)
   );

   assign rsp_data = fgps_pkg::rsp_type'(res_out);

endmodule

`default_nettype wire

@@ tb/frosted_glass_pixel_scatter_top_tb.sv @@
`timescale 1ns / 1ps

module frosted_glass_pixel_scatter_top_tb;

   localparam int MAX_W = 2048;
   localparam int DRAIN_CYCLES = 10;
   localparam int STALL_LIMIT = 1000;
   localparam int RANDOM_PIXELS = 280;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   fgps_pkg::req_type req_data = '0;
   logic full;
   logic empty;
   logic pop = 1'b0;
   fgps_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   fgps_pkg::csr_index_type csr_index = fgps_pkg::CSR_IMAGE_WIDTH;
   logic [fgps_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // pixels waiting to be sent and neighbors still to arrive
   fgps_pkg::req_type pixel_q[$];
   fgps_pkg::rsp_type neighbor_q[$];

   // shadow of the filter state
   logic [11:0] width_reg;
   logic [15:0] height_reg;
   fgps_pkg::pix_type upper_row[MAX_W];
   fgps_pkg::pix_type middle_row[MAX_W];
   fgps_pkg::pix_type window_col[6];
   logic [10:0] col_cnt;
   logic [15:0] row_cnt;

   logic req_fired = 1'b0;
   logic calm = 1'b0;
   int send_gap = 0;
   int take_gap = 0;
   int fail_count = 0;
   int idle_cycles = 0;

   frosted_glass_pixel_scatter_top #(
      .MAX_WIDTH(MAX_W)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .req_data(req_data),
      .full(full),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // advance the shadow filter by one pixel, queue the neighbor it picks
   task automatic predict_scatter(input fgps_pkg::req_type rq);
      int eff_w;
      int eff_h;
      int col;
      int prow;
      int pcol;
      int pk;
      fgps_pkg::pix_type cur[3];
      fgps_pkg::pix_type chosen;
      logic row_end;
      logic img_end;
      fgps_pkg::rsp_type rsp;
      eff_w = (width_reg < 3) ? 3 : ((width_reg > MAX_W) ? MAX_W : int'(width_reg));
      eff_h = (height_reg < 3) ? 3 : int'(height_reg);
      col = col_cnt;
      pk = (rq.pick > fgps_pkg::PICK_MAX) ? int'(fgps_pkg::PICK_MAX) : int'(rq.pick);
      cur[0] = upper_row[col];
      cur[1] = middle_row[col];
      cur[2] = '{c2: rq.chan2, c1: rq.chan1, c0: rq.chan0};
      upper_row[col] = cur[1];
      middle_row[col] = cur[2];
      row_end = (int'(col_cnt) + 1 >= eff_w);
      img_end = row_end && (int'(row_cnt) + 1 >= eff_h);
      // interior pixel completed: pick from the 3x3 window
      if (row_cnt >= 2 && col >= 2) begin
         prow = pk / 3;
         pcol = pk % 3;
         chosen = (pcol == 2) ? cur[prow] : window_col[pcol * 3 + prow];
         rsp.out_chan0 = chosen.c0;
         rsp.out_chan1 = chosen.c1;
         rsp.out_chan2 = chosen.c2;
         rsp.last = img_end;
         neighbor_q.push_back(rsp);
      end
      // shift the window one column left
      for (int k = 0; k < 3; k++) begin
         window_col[k] = window_col[k + 3];
         window_col[k + 3] = cur[k];
      end
      if (row_end) begin
         col_cnt = '0;
         row_cnt = img_end ? '0 : row_cnt + 16'd1;
      end else begin
         col_cnt = col_cnt + 11'd1;
      end
   endtask

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         fail_count++;
      end
   endtask

   task automatic queue_pixels(input int count);
      fgps_pkg::req_type rq;
      for (int k = 0; k < count; k++) begin
         rq.chan0 = 8'($urandom);
         rq.chan1 = 8'($urandom);
         rq.chan2 = 8'($urandom);
         rq.pick = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
         pixel_q.push_back(rq);
      end
   endtask

   // block idle: everything sent, every neighbor back, pipeline flushed
   task automatic wait_idle();
      while (pixel_q.size() != 0 || push || neighbor_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_image_size(input logic [11:0] w, input logic [15:0] h);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= fgps_pkg::CSR_IMAGE_WIDTH;
      csr_wdata <= {4'($urandom), w};
      @(negedge clock);
      csr_index <= fgps_pkg::CSR_IMAGE_HEIGHT;
      csr_wdata <= h;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!push || req_fired) begin
         if (send_gap != 0) begin
            push <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            send_gap <= $urandom_range(0, 4);
         end else if (pixel_q.size() != 0) begin
            req_data <= pixel_q.pop_front();
            push <= 1'b1;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // result sink with random stalls
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (take_gap != 0) begin
         pop <= 1'b0;
         take_gap <= take_gap - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         pop <= 1'b0;
         take_gap <= $urandom_range(0, 4);
      end else begin
         pop <= 1'b1;
      end
   end

   // monitor: shadow update, result check, watchdog
   always @(posedge clock) begin : monitor
      fgps_pkg::rsp_type want;
      req_fired <= !reset && push && !full;
      if (reset) begin
         width_reg = fgps_pkg::IMAGE_WIDTH_RESET;
         height_reg = fgps_pkg::IMAGE_HEIGHT_RESET;
         for (int k = 0; k < MAX_W; k++) begin
            upper_row[k] = '0;
            middle_row[k] = '0;
         end
         for (int k = 0; k < 6; k++) window_col[k] = '0;
         col_cnt = '0;
         row_cnt = '0;
         idle_cycles = 0;
      end else begin
         if (csr_write) begin
            if (csr_index == fgps_pkg::CSR_IMAGE_WIDTH) width_reg = csr_wdata[11:0];
            else height_reg = csr_wdata;
         end
         if (pop && !empty) begin
            if (neighbor_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time,
                        rsp_data);
               fail_count++;
            end else begin
               want = neighbor_q.pop_front();
               check_field("out_chan0", want.out_chan0, rsp_data.out_chan0);
               check_field("out_chan1", want.out_chan1, rsp_data.out_chan1);
               check_field("out_chan2", want.out_chan2, rsp_data.out_chan2);
               check_field("last", 8'(want.last), 8'(rsp_data.last));
            end
         end
         if (push && !full) predict_scatter(req_data);
         if ((push && !full) || (pop && !empty) || csr_write) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      fgps_pkg::req_type rq;
      int w;
      int h;
      int cols;
      int rows;
      int n_img;
      int sent;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed 5x5 image: ramp values, channel extremes, every pick
      write_image_size(12'd5, 16'd5);
      for (int k = 0; k < 25; k++) begin
         rq.chan0 = 8'(k * 10);
         rq.chan1 = 8'(255 - k * 10);
         rq.chan2 = (k % 2) ? 8'hFF : 8'h00;
         rq.pick = 4'(k % 16);
         pixel_q.push_back(rq);
      end

      // sizes below the minimum clamp to 3x3
      wait_idle();
      write_image_size(12'd0, 16'd0);
      queue_pixels(18);
      wait_idle();
      write_image_size(12'd2, 16'd2);
      queue_pixels(9);

      // width above the maximum keeps the first row open, a narrower width ends it
      wait_idle();
      write_image_size(12'hFFF, 16'd3);
      queue_pixels(20);
      wait_idle();
      write_image_size(12'd4, 16'd3);
      queue_pixels(9);

      // tallest height, lowered in the middle of the image
      wait_idle();
      write_image_size(12'd6, 16'hFFFF);
      queue_pixels(24);
      wait_idle();
      write_image_size(12'd6, 16'd3);
      queue_pixels(6);

      // width shrunk past the current column in the middle of a row
      wait_idle();
      write_image_size(12'd10, 16'd6);
      queue_pixels(37);
      wait_idle();
      write_image_size(12'd5, 16'd6);
      queue_pixels(11);

      // random small images
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         w = $urandom_range(0, 12);
         h = $urandom_range(0, 8);
         cols = (w < 3) ? 3 : w;
         rows = (h < 3) ? 3 : h;
         n_img = $urandom_range(1, 2);
         if (sent + cols * rows * n_img > RANDOM_PIXELS) n_img = 1;
         wait_idle();
         write_image_size(12'(w), 16'(h));
         queue_pixels(cols * rows * n_img);
         sent += cols * rows * n_img;
      end

      // tail with no idling on either side
      wait_idle();
      calm = 1'b1;
      write_image_size(12'd7, 16'd4);
      queue_pixels(7 * 4 * 2);
      wait_idle();

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
